@@ rtl/bump_pkg.sv @@
// ============================================================================
// bump_pkg
// Shared widths, controller states and the command/status bundles of the
// bottom-up merge pass block.
// ============================================================================
package bump_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;
    localparam int LEN_W         = 7;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN,
        S_RD,
        S_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // store an accepted request
        logic start;      // begin the pass at index 0
        logic run_setup;  // compute bounds of the next run pair
        logic rd;         // read both run heads
        logic wr;         // write one merged element
        logic emit_init;  // rewind the output index
        logic emit_rd;    // read one merged element
        logic emit_next;  // output taken, advance
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic run_end;    // element being written closes the run pair
        logic pass_end;   // current run pair is the last one
        logic emit_last;  // element on the output is the final one
    } t_sts;

endpackage

@@ rtl/bump_ctrl.sv @@
// ============================================================================
// bump_ctrl
// Sequencer of the merge pass: load, merge run pairs, emit.
// ============================================================================
module bump_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  logic            i_out_ready,
    input  bump_pkg::t_sts  i_sts,
    output bump_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);

    bump_pkg::t_state r_state;
    bump_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bump_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bump_pkg::S_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = bump_pkg::S_RUN;
                end
            end
            bump_pkg::S_RUN: begin
                n_state = bump_pkg::S_RD;
            end
            bump_pkg::S_RD: begin
                n_state = bump_pkg::S_WR;
            end
            bump_pkg::S_WR: begin
                priority if (i_sts.run_end && i_sts.pass_end) begin
                    n_state = bump_pkg::S_EMIT_RD;
                end else if (i_sts.run_end) begin
                    n_state = bump_pkg::S_RUN;
                end else begin
                    n_state = bump_pkg::S_RD;
                end
            end
            bump_pkg::S_EMIT_RD: begin
                n_state = bump_pkg::S_EMIT_OUT;
            end
            bump_pkg::S_EMIT_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.emit_last ? bump_pkg::S_LOAD : bump_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = bump_pkg::S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            bump_pkg::S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = i_in_valid;
                o_cmd.start  = i_in_valid && i_in_last;
            end
            bump_pkg::S_RUN: begin
                o_cmd.run_setup = 1'b1;
            end
            bump_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
            end
            bump_pkg::S_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.emit_init = i_sts.run_end && i_sts.pass_end;
            end
            bump_pkg::S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
            end
            bump_pkg::S_EMIT_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/bump_dp.sv @@
// ============================================================================
// bump_dp
// Element stores, run pointers, merge compare and the run-length register.
// ============================================================================
module bump_dp #(
    parameter int MAX_ITEMS = bump_pkg::MAX_ITEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bump_pkg::t_cmd                   i_cmd,
    input  logic                             i_cfg_valid,
    input  logic [bump_pkg::LEN_W-1:0]       i_cfg_run_length,
    input  logic signed [bump_pkg::DATA_W-1:0] i_value,
    output bump_pkg::t_sts                   o_sts,
    output logic signed [bump_pkg::DATA_W-1:0] o_value_res,
    output logic                             o_last_res
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = ((CW > bump_pkg::LEN_W + 1) ? CW : bump_pkg::LEN_W + 1) + 1;

    logic [bump_pkg::DATA_W-1:0] r_data_mem  [MAX_ITEMS];
    logic [bump_pkg::DATA_W-1:0] r_merge_mem [MAX_ITEMS];

    logic [bump_pkg::LEN_W-1:0]  r_run_len;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_t;
    logic [CW-1:0]               r_l;
    logic [CW-1:0]               r_r;
    logic [CW-1:0]               r_mid;
    logic [CW-1:0]               r_hi;
    logic [CW-1:0]               r_k;
    logic [bump_pkg::DATA_W-1:0] r_rd_l;
    logic [bump_pkg::DATA_W-1:0] r_rd_r;
    logic [bump_pkg::DATA_W-1:0] r_rd_out;

    logic [bump_pkg::LEN_W-1:0]  len;
    logic [SUM_W-1:0]            sum_mid;
    logic [SUM_W-1:0]            sum_hi;
    logic [CW-1:0]               n_mid;
    logic [CW-1:0]               n_hi;
    logic                        take_l;
    logic [bump_pkg::DATA_W-1:0] wr_data;
    logic                        full;

    // a zero run length behaves as one
    assign len     = (r_run_len == '0) ? bump_pkg::LEN_W'(1) : r_run_len;
    assign sum_mid = SUM_W'(r_t) + SUM_W'(len);
    assign sum_hi  = SUM_W'(r_t) + SUM_W'({len, 1'b0});
    assign n_mid   = (sum_mid >= SUM_W'(r_count)) ? r_count : sum_mid[CW-1:0];
    assign n_hi    = (sum_hi  >= SUM_W'(r_count)) ? r_count : sum_hi[CW-1:0];
    assign full    = (r_count == CW'(MAX_ITEMS));

    // stable merge: ties go to the left run
    assign take_l  = (r_l < r_mid) &&
                     ((r_r >= r_hi) || ($signed(r_rd_l) <= $signed(r_rd_r)));
    assign wr_data = take_l ? r_rd_l : r_rd_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len <= bump_pkg::LEN_W'(1);
            r_count   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_run_len <= i_cfg_run_length;
            end
            if (i_cmd.load && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.emit_next && o_last_res) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t <= '0;
        end else if (i_cmd.wr) begin
            r_t <= r_t + CW'(1);
        end
        if (i_cmd.run_setup) begin
            r_l   <= r_t;
            r_r   <= n_mid;
            r_mid <= n_mid;
            r_hi  <= n_hi;
        end else if (i_cmd.wr) begin
            if (take_l) begin
                r_l <= r_l + CW'(1);
            end else begin
                r_r <= r_r + CW'(1);
            end
        end
        if (i_cmd.emit_init) begin
            r_k <= '0;
        end else if (i_cmd.emit_next) begin
            r_k <= r_k + CW'(1);
        end
    end

    // stores: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_data_mem[r_count[AW-1:0]] <= i_value;
        end
        if (i_cmd.rd) begin
            r_rd_l <= r_data_mem[r_l[AW-1:0]];
            r_rd_r <= r_data_mem[r_r[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_merge_mem[r_t[AW-1:0]] <= wr_data;
        end
        if (i_cmd.emit_rd) begin
            r_rd_out <= r_merge_mem[r_k[AW-1:0]];
        end
    end

    assign o_sts.run_end   = ((r_t + CW'(1)) == r_hi);
    assign o_sts.pass_end  = (r_hi == r_count);
    assign o_sts.emit_last = o_last_res;
    assign o_value_res     = r_rd_out;
    assign o_last_res      = ((r_k + CW'(1)) == r_count);

endmodule

@@ rtl/bottom_up_merge_pass_core.sv @@
// ============================================================================
// bottom_up_merge_pass_core
// One pass of bottom-up merge sort over a loaded sequence.
// ============================================================================
// Requests carry one signed 32-bit value each and are stored in order, one per
// cycle, until a request with i_last set arrives (values past MAX_ITEMS are
// dropped, the last marker still counts). Adjacent runs of run_length elements
// are then merged stably, left run winning ties; a short trailing right run is
// merged too and a lone tail is passed through. The result streams out in
// order with o_last_res on the final element. Each run pair (a lone tail counts
// as one) is set up first, then each of its elements is read from the run heads
// and written to the merge store; each result element is then read back and
// offered on the output. Merge and emit steps wait on registered store reads.
// No request is taken from merge start until the final result is taken.
// run_length 0 acts as 1; it may be rewritten only while the block is idle.
// ============================================================================
module bottom_up_merge_pass_core #(
    parameter int MAX_ITEMS = bump_pkg::MAX_ITEMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bump_pkg::LEN_W-1:0]         i_cfg_run_length,
    // input requests
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [bump_pkg::DATA_W-1:0] i_value,
    input  logic                               i_last,
    // output requests
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [bump_pkg::DATA_W-1:0] o_value_res,
    output logic                               o_last_res
);

    bump_pkg::t_cmd cmd;
    bump_pkg::t_sts sts;

    // the user may write the register only while idle; the block does not enforce it and the port always takes writes
    assign o_cfg_ready = 1'b1;

    bump_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_last   (i_last),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid)
    );

    bump_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_run_length (i_cfg_run_length),
        .i_value          (i_value),
        .o_sts            (sts),
        .o_value_res      (o_value_res),
        .o_last_res       (o_last_res)
    );

    // loading and emitting never overlap
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input open while a result is pending");

    // a last marker closes the input until the pass is out
    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> (!o_ready && !o_valid))
        else $error("input still open after last marker");

    // the final result reopens the input
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_res) |=> (o_ready && !o_valid))
        else $error("block not back to loading after final result");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: bottom-up merge pass testbench
// Streams signed sequences into bottom_up_merge_pass_core. A local merge-pass
// predictor builds the expected output stream, and every output request is
// checked against it in order. Directed cases come first, then random
// sequences over many run lengths, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS    = bump_pkg::MAX_ITEMS_DEF;
    localparam int LEN_W        = bump_pkg::LEN_W;
    localparam int LONG_HOLD    = 300;      // cycles the sink refuses output
    localparam int SETTLE       = 4;        // quiet cycles before a cfg write
    localparam int TAIL_CYCLES  = 50;       // quiet cycles at the very end
    localparam int RANDOM_ITEMS = 20;

    typedef logic signed [bump_pkg::DATA_W-1:0] t_word;

    // one element of the merged stream, as it should leave the block
    typedef struct packed {
        t_word value;
        logic  last;
    } t_merged;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [LEN_W-1:0]       i_cfg_run_length;
    logic                   i_valid;
    logic                   o_ready;
    t_word                  i_value;
    logic                   i_last;
    logic                   o_valid;
    logic                   i_ready;
    t_word                  o_value_res;
    logic                   o_last_res;

    bottom_up_merge_pass_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_run_length (i_cfg_run_length),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_value_res      (o_value_res),
        .o_last_res       (o_last_res)
    );

    // ------------------------------------------------------------------
    // Predictor state: the copy of the run length register, the sequence
    // loaded so far, and the merged elements still owed by the block.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] run_len;
    t_word            loaded_seq[$];
    t_word            pass_buf [0:MAX_ITEMS-1];
    t_merged          merged_due[$];

    int err_count;
    int sent_count;
    bit idle_on;        // random idle bursts on both sides
    int hold_asks;      // bumped by a test to ask the sink for a long hold

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Stable merge of pass_buf[lo..mid-1] with pass_buf[mid..hi-1]; on a
    // tie the left run goes first.
    function automatic void merge_span(input int lo, input int mid, input int hi);
        t_word tmp [0:MAX_ITEMS-1];
        int    l;
        int    r;
        int    t;
        l = lo;
        r = mid;
        t = lo;
        while (l < mid && r < hi) begin
            if (pass_buf[l] <= pass_buf[r]) begin
                tmp[t] = pass_buf[l];
                l++;
            end else begin
                tmp[t] = pass_buf[r];
                r++;
            end
            t++;
        end
        while (l < mid) begin
            tmp[t] = pass_buf[l];
            l++;
            t++;
        end
        while (r < hi) begin
            tmp[t] = pass_buf[r];
            r++;
            t++;
        end
        for (t = lo; t < hi; t++) begin
            pass_buf[t] = tmp[t];
        end
    endfunction

    // One bottom-up pass over the loaded sequence; queues the merged stream.
    function automatic void apply_merge_pass();
        int      n;
        int      span;
        int      i;
        int      k;
        t_merged elem;
        n    = loaded_seq.size();
        span = (run_len == 0) ? 1 : int'(run_len);     // zero acts as one
        for (k = 0; k < n; k++) begin
            pass_buf[k] = loaded_seq[k];
        end
        i = 0;
        while (i + 2 * span <= n) begin
            merge_span(i, i + span, i + 2 * span);
            i += 2 * span;
        end
        // trailing pair with a short right run; a lone tail stays put
        if (i + span < n) begin
            merge_span(i, i + span, n);
        end
        for (k = 0; k < n; k++) begin
            elem.value = pass_buf[k];
            elem.last  = (k == n - 1);
            merged_due.push_back(elem);
        end
        loaded_seq.delete();
    endfunction

    // An accepted input request: store it (unless full), run the pass on last.
    function automatic void load_request(input t_word value, input logic last);
        if (loaded_seq.size() < MAX_ITEMS) begin
            loaded_seq.push_back(value);
        end
        if (last) begin
            apply_merge_pass();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_merged(input t_word value, input logic last);
        t_merged want;
        if (merged_due.size() == 0) begin
            report_mismatch($sformatf("unexpected request value %0d last %0b", value, last));
        end else begin
            want = merged_due.pop_front();
            if (value !== want.value) begin
                report_mismatch($sformatf("value %0d, want %0d", value, want.value));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last %0b, want %0b (value %0d)",
                                          last, want.last, want.value));
            end
        end
    endtask

    // outputs are sampled at the rising edge; i_ready only moves on falling edges
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_merged(o_value_res, o_last_res);
        end
    end

    // ------------------------------------------------------------------
    // Sink: random idle bursts, plus a long hold on request from a test.
    // The hold is counted here, independent of the sender.
    // ------------------------------------------------------------------
    initial begin : sink_proc
        int burst;
        int hold_left;
        int hold_seen;
        burst     = 0;
        hold_left = 0;
        hold_seen = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (burst > 0) begin
                i_ready = 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst   = $urandom_range(1, 8) - 1;
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Extremes and small values show up far more often than plain random.
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       pick_word = WORD_MAX;
            1:       pick_word = WORD_MIN;
            2:       pick_word = t_word'($urandom_range(0, 8)) - 4;
            default: pick_word = t_word'($urandom);
        endcase
    endfunction

    // Next element of a nondecreasing run; ties are common, saturates at max.
    function automatic t_word next_in_run(input t_word prev);
        longint sum;
        if ($urandom_range(0, 3) == 0) begin
            sum = longint'(prev);
        end else begin
            sum = longint'(prev) + longint'($urandom_range(1, 100000));
        end
        if (sum > longint'(WORD_MAX)) begin
            sum = longint'(WORD_MAX);
        end
        next_in_run = sum[31:0];
    endfunction

    // Send one input request. Valid stays high after acceptance until the
    // next falling edge, where either a new request or quiet_input takes over.
    task automatic send_item(input t_word value, input logic last);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 8);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = value;
        i_last  = last;
        do @(posedge i_clk); while (!o_ready);
        load_request(value, last);
        sent_count++;
    endtask

    task automatic quiet_input();
        @(negedge i_clk);
        i_valid = 1'b0;
        i_last  = 1'b0;
    endtask

    task automatic wait_drained();
        while (merged_due.size() != 0) @(negedge i_clk);
    endtask

    // One sequence of count requests, last on the final one. With run_sorted
    // it is made of nondecreasing runs of the current run length, which is
    // what a real pass expects; otherwise it is plain noise.
    task automatic send_sequence(input int count, input bit run_sorted);
        int    span;
        int    k;
        t_word value;
        span  = (run_len == 0) ? 1 : int'(run_len);
        value = '0;
        for (k = 0; k < count; k++) begin
            if (!run_sorted || k % span == 0) begin
                value = pick_word();
            end else begin
                value = next_in_run(value);
            end
            send_item(value, k == count - 1);
        end
    endtask

    // The register is only written with the block idle and nothing owed.
    task automatic write_run_length(input logic [LEN_W-1:0] len);
        quiet_input();
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_run_length = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        run_len = len;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset run length of one: extreme values in an even count, so no lone tail
    // is left, then a sequence of a single element.
    task automatic test_value_extremes();
        send_item(WORD_MAX, 1'b0);
        send_item(WORD_MIN, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(WORD_MIN, 1'b1);
        send_item(32'sh5a5a_a5a5, 1'b1);
    endtask

    task automatic test_run_length_edges();
        // zero behaves as a run length of one
        write_run_length('0);
        send_item(32'sd4, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(-32'sd2, 1'b0);
        send_item(-32'sd2, 1'b1);
        // runs of two, with a trailing pair whose right run is short
        write_run_length(7'd2);
        send_item(32'sd5, 1'b0);
        send_item(32'sd9, 1'b0);
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd8, 1'b0);
        send_item(32'sd3, 1'b1);
        // run length at or past the count: sequence passes through unchanged
        write_run_length(7'd64);
        send_item(32'sd30, 1'b0);
        send_item(-32'sd30, 1'b0);
        send_item(32'sd0, 1'b1);
        write_run_length('1);
        send_item(WORD_MAX, 1'b0);
        send_item(WORD_MIN, 1'b1);
    endtask

    // More than MAX_ITEMS requests, then exactly MAX_ITEMS: the extras are
    // dropped but the last marker still starts the pass over what is held.
    task automatic test_store_full();
        write_run_length(7'd32);
        send_sequence(MAX_ITEMS + 3, 1'b1);
        write_run_length(7'd64);
        send_sequence(MAX_ITEMS, 1'b1);
    endtask

    // Sink holds off for a long stretch while the sender keeps offering the
    // next sequence, so the block, with results still owed, refuses input.
    task automatic test_backpressure();
        write_run_length(7'd3);
        hold_asks++;
        send_sequence(12, 1'b1);
        send_sequence(12, 1'b1);
        send_sequence(5, 1'b1);
    endtask

    // Sender waits for every owed result before going on.
    task automatic test_drain_pause();
        send_sequence(9, 1'b1);
        quiet_input();
        wait_drained();
        send_sequence(9, 1'b0);
    endtask

    task automatic test_random_sequences();
        int stop_at;
        int count;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0:       write_run_length('0);
                    1:       write_run_length(7'd1);
                    2:       write_run_length(7'd64);
                    3:       write_run_length('1);
                    default: write_run_length(LEN_W'($urandom_range(2, 9)));
                endcase
            end
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 19))
                    0:       count = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                    1, 2:    count = $urandom_range(17, MAX_ITEMS);
                    default: count = $urandom_range(1, 16);
                endcase
                send_sequence(count, $urandom_range(0, 4) != 0);
            end
        end
        idle_on = 1'b1;
    endtask

    // Closing stretch: no idling on either side, sequences back to back.
    task automatic test_no_idle_tail();
        idle_on = 1'b0;
        write_run_length(7'd4);
        repeat (4) begin
            send_sequence($urandom_range(1, 20), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_value          = '0;
        i_last           = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_run_length = '0;
        idle_on          = 1'b1;
        hold_asks        = 0;
        err_count        = 0;
        sent_count       = 0;
        run_len          = 7'd1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_value_extremes();
        test_run_length_edges();
        test_store_full();
        test_backpressure();
        test_drain_pause();
        test_random_sequences();
        test_no_idle_tail();

        quiet_input();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bump_pkg.sv
rtl/bump_ctrl.sv
rtl/bump_dp.sv
rtl/bottom_up_merge_pass_core.sv
tb/tb.sv
